/* src/float64_ieee_remainder_top_macros.svh */
// ----------------------------------------------------------------------------
// float64_ieee_remainder_top_macros
// assertion macros shared by the remainder block
// ----------------------------------------------------------------------------
`ifndef FLOAT64_IEEE_REMAINDER_TOP_MACROS_SVH
`define FLOAT64_IEEE_REMAINDER_TOP_MACROS_SVH

// plain property checked on the rising clock, idle during reset
`define F64REM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication form
`define F64REM_ASSERT_IMP(lbl, ante, cons, msg) \
    `F64REM_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* src/f64rem_pkg.sv */
// ----------------------------------------------------------------------------
// f64rem_pkg
// shared types and constants of the binary64 remainder block
// ----------------------------------------------------------------------------
package f64rem_pkg;

    localparam int MANT_W = 53;
    localparam int EXP_W  = 11;
    localparam int CNT_W  = 12;
    localparam int DATA_W = 64;
    localparam logic [DATA_W-1:0] DEFAULT_QNAN = 64'h7FF8_0000_0000_0000;
    localparam logic [EXP_W-1:0]  EXP_ALL      = 11'h7FF;
    localparam logic [EXP_W-1:0]  EXP_MIN      = 11'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FIX,
        S_NORM,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic fix;
        logic norm;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic norm_done;
    } t_sts;

endpackage

/* src/f64rem_dp.sv */
// ----------------------------------------------------------------------------
// f64rem_dp
// operand decode, restoring division, rounding fix-up and normalization
// ----------------------------------------------------------------------------
module f64rem_dp
    import f64rem_pkg::*;
(
    input  logic              i_clk,
    input  logic [DATA_W-1:0] i_x,
    input  logic [DATA_W-1:0] i_y,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic [DATA_W-1:0] o_rem,
    output logic              o_dom
);

    logic [MANT_W-1:0] r_r, n_r, r_q, n_q, r_my, n_my;
    logic [EXP_W-1:0]  r_e, n_e;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_odd, n_odd, r_half, n_half, r_sign, n_sign, r_xsign, n_xsign;
    logic              r_byp, n_byp, r_bdom, n_bdom;
    logic [DATA_W-1:0] r_bval, n_bval, r_out, n_out;
    logic              r_dom, n_dom;

    // operand decode
    logic [EXP_W-1:0]  xe, ye, ex, ey;
    logic              xnan, ynan, xinf, yinf, xzero, yzero;
    logic [MANT_W-1:0] mx, my;
    logic [EXP_W:0]    ey_p1;
    // datapath terms
    logic [MANT_W:0]   r2, ydiv, r2x, rsub;
    logic              ge;
    logic [DATA_W-2:0] mag;

    always_comb begin
        xe    = i_x[62:52];
        ye    = i_y[62:52];
        xnan  = (xe == EXP_ALL) && (i_x[51:0] != '0);
        ynan  = (ye == EXP_ALL) && (i_y[51:0] != '0);
        xinf  = (xe == EXP_ALL) && (i_x[51:0] == '0);
        yinf  = (ye == EXP_ALL) && (i_y[51:0] == '0);
        xzero = (i_x[62:0] == '0);
        yzero = (i_y[62:0] == '0);
        ex    = (xe == '0) ? EXP_MIN : xe;
        ey    = (ye == '0) ? EXP_MIN : ye;
        mx    = {(xe != '0), i_x[51:0]};
        my    = {(ye != '0), i_y[51:0]};
        ey_p1 = {1'b0, ey} - {1'b0, ex};

        r2   = {r_r, r_q[MANT_W-1]};
        ge   = (r2 >= {1'b0, r_my});
        ydiv = r_half ? {r_my, 1'b0} : {1'b0, r_my};
        r2x  = {r_r, 1'b0};
        rsub = ydiv - {1'b0, r_r};

        if (r_r == '0) begin
            mag = '0;
        end else if (!r_r[MANT_W-1]) begin
            mag = {{EXP_W{1'b0}}, r_r[MANT_W-2:0]};
        end else begin
            mag = {r_e, r_r[MANT_W-2:0]};
        end
    end

    always_comb begin
        n_r = r_r; n_q = r_q; n_my = r_my; n_e = r_e; n_cnt = r_cnt;
        n_odd = r_odd; n_half = r_half; n_sign = r_sign; n_xsign = r_xsign;
        n_byp = r_byp; n_bdom = r_bdom; n_bval = r_bval; n_out = r_out; n_dom = r_dom;

        if (i_cmd.load) begin
            n_q = mx; n_my = my; n_sign = i_x[63]; n_xsign = i_x[63];
            n_odd = 1'b0; n_half = 1'b0; n_r = '0; n_cnt = '0; n_e = ey;
            n_byp = 1'b1; n_bdom = 1'b1; n_bval = i_x;
            if (xnan) begin
                n_bval = i_x;
            end else if (ynan) begin
                n_bval = i_y;
            end else if (xinf || yzero) begin
                n_bval = DEFAULT_QNAN;
            end else if (xzero || yinf) begin
                n_bdom = 1'b0;
            end else if (ex >= ey) begin
                n_byp = 1'b0;
                // all mantissa bits of x, then one step per exponent difference
                n_cnt = CNT_W'(MANT_W) + CNT_W'(ex - ey);
            end else if (ey_p1 == (EXP_W+1)'(1)) begin
                n_byp = 1'b0; n_half = 1'b1; n_r = mx; n_e = ex;
            end else begin
                n_bdom = 1'b0;
            end
        end

        if (i_cmd.step) begin
            n_q   = {r_q[MANT_W-2:0], 1'b0};
            n_odd = ge;
            n_r   = ge ? MANT_W'(r2 - {1'b0, r_my}) : r2[MANT_W-1:0];
            n_cnt = r_cnt - 1'b1;
        end

        // round to nearest, ties to the even quotient
        if (i_cmd.fix && !r_byp) begin
            if (r2x > ydiv || (r2x == ydiv && r_odd)) begin
                n_r    = rsub[MANT_W-1:0];
                n_sign = ~r_sign;
            end
        end

        if (i_cmd.norm) begin
            n_r = {r_r[MANT_W-2:0], 1'b0};
            n_e = r_e - 1'b1;
        end

        if (i_cmd.emit) begin
            n_out = r_byp ? r_bval : {((mag == '0) ? r_xsign : r_sign), mag};
            n_dom = r_byp & r_bdom;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r <= n_r; r_q <= n_q; r_my <= n_my; r_e <= n_e; r_cnt <= n_cnt;
        r_odd <= n_odd; r_half <= n_half; r_sign <= n_sign; r_xsign <= n_xsign;
        r_byp <= n_byp; r_bdom <= n_bdom; r_bval <= n_bval;
        r_out <= n_out; r_dom <= n_dom;
    end

    assign o_sts.cnt_zero  = (r_cnt == '0);
    assign o_sts.norm_done = r_byp || (r_r == '0) || r_r[MANT_W-1] || (r_e == EXP_MIN);
    assign o_rem = r_out;
    assign o_dom = r_dom;

endmodule

/* src/f64rem_ctrl.sv */
// ----------------------------------------------------------------------------
// f64rem_ctrl
// sequencer for load, division steps, fix-up, normalization and output
// ----------------------------------------------------------------------------
`include "float64_ieee_remainder_top_macros.svh"

module f64rem_ctrl
    import f64rem_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.cnt_zero) n_state = S_FIX;
                else o_cmd.step = 1'b1;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_NORM;
            end
            S_NORM: begin
                if (i_sts.norm_done) n_state = S_EMIT;
                else o_cmd.norm = 1'b1;
            end
            S_EMIT: begin
                // output register free or being drained this cycle
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ovalid = o_cmd.emit ? 1'b1 : (i_out_ready ? 1'b0 : r_ovalid);
    end

    assign o_out_valid = r_ovalid;

    `F64REM_ASSERT_IMP(a_step_cnt, o_cmd.step, !i_sts.cnt_zero, "step with empty count")
    `F64REM_ASSERT_IMP(a_emit_free, o_cmd.emit, !r_ovalid || i_out_ready, "output overwritten")
    `F64REM_ASSERT(a_load_div, o_cmd.load |=> (r_state == S_DIV), "load not followed by divide")

endmodule

/* src/float64_ieee_remainder_top.sv */
// from accept to output valid: load, division steps, rounding fix-up, normalize shifts, output;
// 53 + (exponent difference) division steps when ex >= ey, up to 52 shifts
// one item at a time: the shared restoring subtractor makes one quotient bit a cycle
// a new item is taken while the previous result waits in the output register
// reset: synchronous active-low i_rst_n clears the sequencer and the output valid
// ----------------------------------------------------------------------------
// float64_ieee_remainder_top
// IEEE-754 binary64 remainder x - n*y with n rounded to nearest even
// ----------------------------------------------------------------------------
module float64_ieee_remainder_top
    import f64rem_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [2*DATA_W-1:0] i_s_tdata,   // divisor_bits (high half), dividend_bits (low half)
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [DATA_W-1:0]   o_m_tdata,   // remainder_bits
    output logic                o_m_tuser    // domain_error
);

    t_cmd cmd;
    t_sts sts;

    f64rem_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    f64rem_dp u_dp (
        .i_clk (i_clk),
        .i_x   (i_s_tdata[DATA_W-1:0]),
        .i_y   (i_s_tdata[2*DATA_W-1:DATA_W]),
        .i_cmd (cmd),
        .o_sts (sts),
        .o_rem (o_m_tdata),
        .o_dom (o_m_tuser)
    );

endmodule
